// ----- hdl/ius_pkg.sv -----
// Shared types, widths and constants for the integer upscale pixel blit.
package ius_pkg;

  // Field widths
  localparam int COL_W     = 9;
  localparam int ROW_W     = 8;
  localparam int PIX_W     = 32;
  localparam int IDX_W     = 24;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // Default geometry of the source frame and the scale cap
  localparam int SRC_WIDTH_DEF  = 320;
  localparam int SRC_HEIGHT_DEF = 200;
  localparam int MAX_SCALE_DEF  = 8;

  // Sub-row / sub-column counters cover scales up to 8
  localparam int SUB_W   = 3;
  localparam int SCALE_W = SUB_W + 1;

  // Signed framebuffer coordinate, wide enough for offset plus scaled position
  localparam int COORD_W = 16;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Alpha byte forced on every write
  localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

  // Register reset values
  localparam logic [CFG_W-1:0] FB_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FB_HEIGHT_RST = 13'd480;
  localparam logic [CFG_W-1:0] PITCH_RST     = 13'd640;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FB_WIDTH  = 2'd0,
    CFG_FB_HEIGHT = 2'd1,
    CFG_PITCH     = 2'd2
  } cfg_reg_e;

  // Configuration register set
  typedef struct packed {
    logic [CFG_W-1:0] fb_width;
    logic [CFG_W-1:0] fb_height;
    logic [CFG_W-1:0] pitch_words;
  } cfg_t;

  // One classified request handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx;      // word index of the first kept write
    logic [PIX_W-1:0] pixel;    // pixel with alpha already forced
    logic [SUB_W-1:0] last_sy;  // kept sub-rows minus one
    logic [SUB_W-1:0] last_sx;  // kept sub-columns minus one
  } job_t;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

endpackage

// ----- hdl/ius_in_if.sv -----
// Source pixel request channel.
interface ius_in_if import ius_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] src_col;
  logic [ROW_W-1:0] src_row;
  logic [PIX_W-1:0] src_pixel;

  modport source (output valid, output src_col, output src_row, output src_pixel,
                  input ready);
  modport sink   (input valid, input src_col, input src_row, input src_pixel,
                  output ready);
endinterface

// ----- hdl/ius_out_if.sv -----
// Framebuffer write channel.
interface ius_out_if import ius_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] word_index;
  logic [PIX_W-1:0] out_pixel;
  logic             last_write;

  modport source (output valid, output word_index, output out_pixel, output last_write,
                  input ready);
  modport sink   (input valid, input word_index, input out_pixel, input last_write,
                  output ready);
endinterface

// ----- hdl/ius_front.sv -----
// Front end: takes requests, computes placement and clipping, builds jobs.
module ius_front import ius_pkg::*; #(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
  parameter int MAX_SCALE  = MAX_SCALE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     cfg_we,
  ius_in_if.sink   in_ch,
  output logic     q_push,
  output job_t     q_job,
  input  logic     q_full
);

  // Derived geometry, registered from the configuration registers
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  coord_t             off_x_r, off_x_nxt;
  coord_t             off_y_r, off_y_nxt;
  coord_t             diff_x, diff_y;

  // Stage 1: captured request
  logic             s1_v_r, s1_v_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [PIX_W-1:0] s1_pix_r;

  // Stage 2: clip result
  logic             s2_v_r, s2_v_nxt;
  logic             s2_drop_r;
  coord_t           s2_base_row_r, s2_base_col_r;
  logic [SUB_W-1:0] s2_fsy_r, s2_fsx_r, s2_nsy_r, s2_nsx_r;
  logic [PIX_W-1:0] s2_pix_r;

  // Stage 3: finished job
  logic s3_v_r, s3_v_nxt;
  logic s3_drop_r;
  job_t s3_job_r, s3_job_nxt;

  // Classification signals
  coord_t               base_row, base_col;
  coord_t               sub_row [MAX_SCALE];
  coord_t               sub_col [MAX_SCALE];
  logic [MAX_SCALE-1:0] row_ok, col_ok;
  logic [SUB_W-1:0]     fsy, lsy, fsx, lsx;
  logic                 drop;

  // Index computation
  coord_t                start_row, start_col;
  logic [2*CFG_W-1:0]    row_prod;

  // Flow control
  logic s1_free, s2_free, s3_free, s3_go, in_take;

  // Scale and centring offsets from the current registers
  always_comb begin
    scale_nxt = SCALE_W'(1);
    for (int k = 2; k <= MAX_SCALE; k++) begin
      if ({1'b0, cfg.fb_width} >= (CFG_W+1)'(k * SRC_WIDTH)) begin
        scale_nxt = SCALE_W'(k);
      end
    end
    diff_x = coord_t'(cfg.fb_width) - coord_t'(SRC_WIDTH) * coord_t'(scale_nxt);
    diff_y = coord_t'(cfg.fb_height) - coord_t'(SRC_HEIGHT) * coord_t'(scale_nxt);
    // halve, rounding toward zero
    off_x_nxt = (diff_x + coord_t'(diff_x[COORD_W-1])) >>> 1;
    off_y_nxt = (diff_y + coord_t'(diff_y[COORD_W-1])) >>> 1;
  end

  always_ff @(posedge clk) begin
    scale_r <= scale_nxt;
    off_x_r <= off_x_nxt;
    off_y_r <= off_y_nxt;
  end

  // Pipeline handshake; a request is held off during a register write
  assign s3_go    = s3_v_r && (s3_drop_r || !q_full);
  assign s3_free  = !s3_v_r || s3_go;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free && !cfg_we;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign q_push   = s3_v_r && !s3_drop_r && !q_full;
  assign q_job    = s3_job_r;

  assign s1_v_nxt = s1_free ? in_take : s1_v_r;
  assign s2_v_nxt = s2_free ? s1_v_r : s2_v_r;
  assign s3_v_nxt = s3_free ? s2_v_r : s3_v_r;

  // Block origin and per-sub-position clipping
  always_comb begin
    base_row = off_y_r + coord_t'(s1_row_r) * coord_t'(scale_r);
    base_col = off_x_r + coord_t'(s1_col_r) * coord_t'(scale_r);
    for (int i = 0; i < MAX_SCALE; i++) begin
      sub_row[i] = base_row + coord_t'(i);
      sub_col[i] = base_col + coord_t'(i);
      row_ok[i]  = (SCALE_W'(i) < scale_r) && !sub_row[i][COORD_W-1] &&
                   (sub_row[i] < coord_t'(cfg.fb_height));
      col_ok[i]  = (SCALE_W'(i) < scale_r) && !sub_col[i][COORD_W-1] &&
                   (sub_col[i] < coord_t'(cfg.fb_width));
    end
    // first and last kept sub-row / sub-column
    fsy = '0;
    fsx = '0;
    for (int i = MAX_SCALE - 1; i >= 0; i--) begin
      if (row_ok[i]) fsy = SUB_W'(i);
      if (col_ok[i]) fsx = SUB_W'(i);
    end
    lsy = '0;
    lsx = '0;
    for (int i = 0; i < MAX_SCALE; i++) begin
      if (row_ok[i]) lsy = SUB_W'(i);
      if (col_ok[i]) lsx = SUB_W'(i);
    end
    drop = !(|row_ok) || !(|col_ok);
  end

  // Word index of the first kept write
  always_comb begin
    start_row = s2_base_row_r + coord_t'(s2_fsy_r);
    start_col = s2_base_col_r + coord_t'(s2_fsx_r);
    row_prod  = (2*CFG_W)'(start_row[CFG_W-1:0]) * (2*CFG_W)'(cfg.pitch_words);
    s3_job_nxt.idx     = IDX_W'(row_prod + (2*CFG_W)'(start_col[CFG_W-1:0]));
    s3_job_nxt.pixel   = s2_pix_r;
    s3_job_nxt.last_sy = s2_nsy_r;
    s3_job_nxt.last_sx = s2_nsx_r;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_col_r <= in_ch.src_col;
      s1_row_r <= in_ch.src_row;
      s1_pix_r <= in_ch.src_pixel | ALPHA_OPAQUE;
    end
    if (s2_free) begin
      s2_drop_r     <= drop;
      s2_base_row_r <= base_row;
      s2_base_col_r <= base_col;
      s2_fsy_r      <= fsy;
      s2_fsx_r      <= fsx;
      s2_nsy_r      <= lsy - fsy;
      s2_nsx_r      <= lsx - fsx;
      s2_pix_r      <= s1_pix_r;
    end
    if (s3_free) begin
      s3_drop_r <= s2_drop_r;
      s3_job_r  <= s3_job_nxt;
    end
  end

endmodule

// ----- hdl/ius_queue.sv -----
// Small job queue between the front end and the write engine.
module ius_queue import ius_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_job
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_job = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ----- hdl/ius_back.sv -----
// Write engine: walks a job's kept block, one write a cycle if out_ch is ready.
module ius_back import ius_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] pitch_words,
  input  logic             q_valid,
  input  job_t             q_job,
  output logic             q_pop,
  ius_out_if.source        out_ch
);

  // Walk state
  logic             active_r, active_nxt;
  logic [SUB_W-1:0] sy_r, sy_nxt, sx_r, sx_nxt;
  logic [SUB_W-1:0] last_sy_r, last_sy_nxt, last_sx_r, last_sx_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, row_idx_r, row_idx_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_load, emit, is_last, take;
  logic [IDX_W-1:0] next_row_idx;

  assign out_load     = !out_valid_r || out_ch.ready;
  assign emit         = active_r && out_load;
  assign is_last      = (sy_r == last_sy_r) && (sx_r == last_sx_r);
  assign take         = q_valid && (!active_r || (emit && is_last));
  assign q_pop        = take;
  assign next_row_idx = row_idx_r + IDX_W'(pitch_words);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.word_index = out_idx_r;
  assign out_ch.out_pixel  = out_pix_r;
  assign out_ch.last_write = out_last_r;

  // Walk: sub-columns inside sub-rows, next job loaded on the last write
  always_comb begin
    active_nxt  = active_r;
    sy_nxt      = sy_r;
    sx_nxt      = sx_r;
    last_sy_nxt = last_sy_r;
    last_sx_nxt = last_sx_r;
    idx_nxt     = idx_r;
    row_idx_nxt = row_idx_r;
    pix_nxt     = pix_r;
    if (take) begin
      active_nxt  = 1'b1;
      sy_nxt      = '0;
      sx_nxt      = '0;
      last_sy_nxt = q_job.last_sy;
      last_sx_nxt = q_job.last_sx;
      idx_nxt     = q_job.idx;
      row_idx_nxt = q_job.idx;
      pix_nxt     = q_job.pixel;
    end else if (emit && is_last) begin
      active_nxt = 1'b0;
    end else if (emit) begin
      if (sx_r == last_sx_r) begin
        sx_nxt      = '0;
        sy_nxt      = sy_r + 1'b1;
        row_idx_nxt = next_row_idx;
        idx_nxt     = next_row_idx;
      end else begin
        sx_nxt  = sx_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  // Output slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = idx_r;
      out_pix_nxt   = pix_r;
      out_last_nxt  = is_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sy_r       <= sy_nxt;
    sx_r       <= sx_nxt;
    last_sy_r  <= last_sy_nxt;
    last_sx_r  <= last_sx_nxt;
    idx_r      <= idx_nxt;
    row_idx_r  <= row_idx_nxt;
    pix_r      <= pix_nxt;
    out_idx_r  <= out_idx_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ----- hdl/integer_upscale_pixel_blit.sv -----
// Path: front stages s1, s2 and s3, the job queue, walk state and output register to out_ch.
// Rate: the write engine gives one framebuffer write per cycle while out_ch is ready;
//   each request gives its kept writes (scale squared when unclipped, four at scale 2).
// Fully clipped requests are dropped in the front end.
// Input ready is low in the cycle of a register write.
// Reset (rst_n, synchronous, active low) empties pipeline and queue, sets 640/480/640.
module integer_upscale_pixel_blit import ius_pkg::*; #(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
  parameter int MAX_SCALE  = MAX_SCALE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ius_in_if.sink               in_ch,
  ius_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_pop, q_valid;
  job_t q_push_job, q_pop_job;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_FB_WIDTH:  cfg_nxt.fb_width    = cfg_data;
        CFG_FB_HEIGHT: cfg_nxt.fb_height   = cfg_data;
        CFG_PITCH:     cfg_nxt.pitch_words = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width    <= FB_WIDTH_RST;
      cfg_r.fb_height   <= FB_HEIGHT_RST;
      cfg_r.pitch_words <= PITCH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Placement and clipping
  ius_front #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT),
    .MAX_SCALE  (MAX_SCALE)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .cfg_we (cfg_we),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_job  (q_push_job),
    .q_full (q_full)
  );

  // Job queue
  ius_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (q_pop_job)
  );

  // Write engine
  ius_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pitch_words (cfg_r.pitch_words),
    .q_valid     (q_valid),
    .q_job       (q_pop_job),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
